// File: hw/rtl/dtq_pkg.sv
// Shared constants and types of the deadline timer queue.
// Used by the channel interfaces, the timer cell and the top level.
`default_nettype none

package dtq_pkg;

  localparam int CAPACITY_DEFAULT  = 16;
  localparam int TIME_BITS_DEFAULT = 48;

  localparam int OP_W         = 3;
  localparam int ID_W         = 32;
  localparam int TIME_FIELD_W = 48;
  localparam int STATUS_W     = 2;

  typedef enum logic [OP_W-1:0] {
    OP_TICK      = 3'd0,
    OP_REG_REL   = 3'd1,
    OP_REG_ABS   = 3'd2,
    OP_CANCEL    = 3'd3,
    OP_QUERY_REM = 3'd4,
    OP_QUERY_END = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/dtq_req_if.sv
// Request channel of the deadline timer queue: valid, ready and one command.
// Depends on dtq_pkg for the field widths.
`default_nettype none

interface dtq_req_if;
  logic                            valid;
  logic                            ready;
  logic [dtq_pkg::OP_W-1:0]         op;
  logic [dtq_pkg::TIME_FIELD_W-1:0] time_value;
  logic [dtq_pkg::ID_W-1:0]         timer_id;

  modport source (output valid, output op, output time_value, output timer_id, input ready);
  modport sink (input valid, input op, input time_value, input timer_id, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dtq_rsp_if.sv
// Result channel of the deadline timer queue: valid, ready and one result.
// Depends on dtq_pkg for the field widths.
`default_nettype none

interface dtq_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            fired;
  logic [dtq_pkg::ID_W-1:0]         result_id;
  logic [dtq_pkg::STATUS_W-1:0]     status;
  logic [dtq_pkg::TIME_FIELD_W-1:0] result_time;
  logic                            last;

  modport source (output valid, output fired, output result_id, output status,
                  output result_time, output last, input ready);
  modport sink (input valid, input fired, input result_id, input status,
                input result_time, input last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dtq_cell.sv
// One timer slot of the queue: holds a valid bit, an id and an end time, and
// acts on the request packet passing through before handing it on. Uses dtq_pkg.
`default_nettype none

module dtq_cell #(
  parameter int CAPACITY  = dtq_pkg::CAPACITY_DEFAULT,
  parameter int TIME_BITS = dtq_pkg::TIME_BITS_DEFAULT,
  parameter int INDEX     = 0
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic [1+$clog2(CAPACITY)-1:0] clr,
  input  wire logic [1+dtq_pkg::OP_W+2*dtq_pkg::ID_W+2*TIME_BITS+1+$clog2(CAPACITY)
                     +$clog2(CAPACITY+1)-1:0] pkt_in,
  output      logic [1+dtq_pkg::OP_W+2*dtq_pkg::ID_W+2*TIME_BITS+1+$clog2(CAPACITY)
                     +$clog2(CAPACITY+1)-1:0] pkt_out
);

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ID_W   = dtq_pkg::ID_W;

  typedef struct packed {
    logic                valid;
    dtq_pkg::op_t        op;
    logic [ID_W-1:0]      key_id;
    logic [TIME_BITS-1:0] key_end;
    logic                found;
    logic [SLOT_W-1:0]    slot;
    logic [ID_W-1:0]      best_id;
    logic [TIME_BITS-1:0] best_end;
    logic [CNT_W-1:0]     count;
  } pkt_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
  } clr_t;

  localparam logic [SLOT_W-1:0] SLOT = SLOT_W'(INDEX);

  pkt_t p;
  pkt_t q;
  pkt_t q_reg;
  clr_t c;

  logic                 ent_valid;
  logic [ID_W-1:0]      ent_id;
  logic [TIME_BITS-1:0] ent_end;
  logic                 ent_valid_next;
  logic                 ent_write;
  logic                 hit;
  logic                 expired;
  logic                 better;

  assign p       = pkt_t'(pkt_in);
  assign c       = clr_t'(clr);
  assign pkt_out = q_reg;

  assign hit     = ent_valid && (ent_id == p.key_id);
  assign expired = ent_valid && (ent_end <= p.key_end);
  assign better  = !p.found || (ent_end < p.best_end) ||
                   ((ent_end == p.best_end) && (ent_id < p.best_id));

  always_comb begin
    q              = p;
    ent_valid_next = ent_valid;
    ent_write      = 1'b0;
    if (c.en && (c.slot == SLOT)) begin
      ent_valid_next = 1'b0;
    end
    if (p.valid) begin
      case (p.op)
        dtq_pkg::OP_REG_REL, dtq_pkg::OP_REG_ABS: begin
          if (!p.found && !ent_valid) begin
            ent_valid_next = 1'b1;
            ent_write      = 1'b1;
            q.found        = 1'b1;
          end
        end
        dtq_pkg::OP_CANCEL: begin
          if (!p.found && hit) begin
            ent_valid_next = 1'b0;
            q.found        = 1'b1;
          end
        end
        dtq_pkg::OP_QUERY_REM, dtq_pkg::OP_QUERY_END: begin
          if (!p.found && hit) begin
            q.found    = 1'b1;
            q.best_end = ent_end;
          end
        end
        dtq_pkg::OP_TICK: begin
          if (expired) begin
            q.count = p.count + CNT_W'(1);
            if (better) begin
              q.found    = 1'b1;
              q.best_id  = ent_id;
              q.best_end = ent_end;
              q.slot     = SLOT;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid   <= 1'b0;
      q_reg.valid <= 1'b0;
    end else begin
      ent_valid <= ent_valid_next;
      q_reg     <= q;
    end
  end

  always_ff @(posedge clk) begin
    if (ent_write) begin
      ent_id  <= p.key_id;
      ent_end <= p.key_end;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/deadline_timer_queue.sv
// Top level of the deadline timer queue: command sequencer, time and id
// counters, result register and the chain of dtq_cell slots. Uses dtq_pkg.
`default_nettype none

// Every accepted command is turned into a packet that walks the row of
// CAPACITY timer cells, one cell per cycle, and returns to the sequencer,
// which takes no new command until the current one has finished. A tick
// makes one walk per expired timer (one walk if none has expired) and
// produces one result per expired timer. Undefined opcodes are dropped
// without a walk. A result waits in an output register, and the sequencer
// only holds a finished walk when that register is still full.
module deadline_timer_queue #(
  parameter int CAPACITY  = dtq_pkg::CAPACITY_DEFAULT,
  parameter int TIME_BITS = dtq_pkg::TIME_BITS_DEFAULT
) (
  input wire logic clk,
  input wire logic rst,
  dtq_req_if.sink   req,
  dtq_rsp_if.source rsp
);

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ID_W   = dtq_pkg::ID_W;
  localparam int FW     = dtq_pkg::TIME_FIELD_W;
  localparam int MIN_W  = (TIME_BITS < FW) ? TIME_BITS : FW;
  localparam int PKT_W  = 1 + dtq_pkg::OP_W + 2 * ID_W + 2 * TIME_BITS + 1 + SLOT_W + CNT_W;

  typedef struct packed {
    logic                valid;
    dtq_pkg::op_t        op;
    logic [ID_W-1:0]      key_id;
    logic [TIME_BITS-1:0] key_end;
    logic                found;
    logic [SLOT_W-1:0]    slot;
    logic [ID_W-1:0]      best_id;
    logic [TIME_BITS-1:0] best_end;
    logic [CNT_W-1:0]     count;
  } pkt_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
  } clr_t;

  dtq_pkg::state_t state;
  dtq_pkg::state_t state_next;

  logic [TIME_BITS-1:0] cur_time;
  logic [TIME_BITS-1:0] cur_time_next;
  logic [ID_W-1:0]      next_id;
  logic [ID_W-1:0]      next_id_next;
  pkt_t                 inj;
  pkt_t                 inj_next;
  pkt_t                 done;
  pkt_t                 done_next;

  logic                 out_valid;
  logic                 out_valid_next;
  logic                 out_fired;
  logic                 out_fired_next;
  logic [ID_W-1:0]      out_id;
  logic [ID_W-1:0]      out_id_next;
  dtq_pkg::status_t     out_status;
  dtq_pkg::status_t     out_status_next;
  logic [FW-1:0]        out_time;
  logic [FW-1:0]        out_time_next;
  logic                 out_last;
  logic                 out_last_next;
  logic                 out_load;

  clr_t                 clr;
  pkt_t                 chain [CAPACITY+1];
  logic [CAPACITY:0]    chain_vld;

  logic [TIME_BITS-1:0] tv;
  logic [TIME_BITS:0]   sum;
  logic [TIME_BITS-1:0] rel_end;
  logic [TIME_BITS-1:0] tick_time;
  logic [TIME_BITS-1:0] remain;
  logic [TIME_BITS-1:0] res_time;
  logic                 req_xfer;

  assign chain[0] = inj;
  assign chain_vld[0] = inj.valid;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cells
    logic [PKT_W-1:0] cell_out;
    dtq_cell #(
      .CAPACITY  (CAPACITY),
      .TIME_BITS (TIME_BITS),
      .INDEX     (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .clr     (clr),
      .pkt_in  (chain[i]),
      .pkt_out (cell_out)
    );
    assign chain[i+1]     = pkt_t'(cell_out);
    assign chain_vld[i+1] = chain[i+1].valid;
  end

  assign req.ready = (state == dtq_pkg::ST_IDLE);
  assign req_xfer  = req.valid && req.ready;

  assign rsp.valid       = out_valid;
  assign rsp.fired       = out_fired;
  assign rsp.result_id   = out_id;
  assign rsp.status      = out_status;
  assign rsp.result_time = out_time;
  assign rsp.last        = out_last;

  always_comb begin
    tv = '0;
    tv[MIN_W-1:0] = req.time_value[MIN_W-1:0];
  end

  assign sum       = {1'b0, cur_time} + {1'b0, tv};
  assign rel_end   = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
  assign tick_time = (cur_time == '1) ? cur_time : cur_time + TIME_BITS'(1);
  assign remain    = (done.best_end > cur_time) ? done.best_end - cur_time : '0;

  always_comb begin
    state_next      = state;
    cur_time_next   = cur_time;
    next_id_next    = next_id;
    inj_next        = inj;
    inj_next.valid  = 1'b0;
    done_next       = done;
    out_load        = 1'b0;
    out_valid_next  = out_valid && !rsp.ready;
    out_fired_next  = 1'b0;
    out_id_next     = '0;
    out_status_next = dtq_pkg::STATUS_OK;
    res_time        = '0;
    out_last_next   = 1'b1;
    clr             = '0;

    case (state)
      dtq_pkg::ST_IDLE: begin
        if (req_xfer && (req.op <= dtq_pkg::OP_QUERY_END)) begin
          inj_next          = '0;
          inj_next.valid    = 1'b1;
          inj_next.op       = dtq_pkg::op_t'(req.op);
          inj_next.key_id   = req.timer_id;
          case (dtq_pkg::op_t'(req.op))
            dtq_pkg::OP_TICK: begin
              inj_next.key_end = tick_time;
              cur_time_next    = tick_time;
            end
            dtq_pkg::OP_REG_REL: begin
              inj_next.key_end = rel_end;
              inj_next.key_id  = next_id;
            end
            dtq_pkg::OP_REG_ABS: begin
              inj_next.key_end = tv;
              inj_next.key_id  = next_id;
            end
            default: begin
            end
          endcase
          state_next = dtq_pkg::ST_SWEEP;
        end
      end

      dtq_pkg::ST_SWEEP: begin
        if (chain[CAPACITY].valid) begin
          done_next  = chain[CAPACITY];
          state_next = dtq_pkg::ST_FINISH;
        end
      end

      dtq_pkg::ST_FINISH: begin
        if ((done.op == dtq_pkg::OP_TICK) && (done.count == '0)) begin
          state_next = dtq_pkg::ST_IDLE;
        end else if (!out_valid || rsp.ready) begin
          out_load       = 1'b1;
          out_valid_next = 1'b1;
          out_id_next    = done.key_id;
          state_next     = dtq_pkg::ST_IDLE;
          case (done.op)
            dtq_pkg::OP_REG_REL, dtq_pkg::OP_REG_ABS: begin
              res_time = done.key_end;
              if (done.found) begin
                next_id_next = next_id + ID_W'(1);
              end else begin
                out_id_next     = '0;
                out_status_next = dtq_pkg::STATUS_FULL;
              end
            end
            dtq_pkg::OP_CANCEL: begin
              if (!done.found) begin
                out_status_next = dtq_pkg::STATUS_NOT_FOUND;
              end
            end
            dtq_pkg::OP_QUERY_REM: begin
              if (done.found) begin
                res_time = remain;
              end else begin
                out_status_next = dtq_pkg::STATUS_NOT_FOUND;
              end
            end
            dtq_pkg::OP_QUERY_END: begin
              if (done.found) begin
                res_time = done.best_end;
              end else begin
                out_status_next = dtq_pkg::STATUS_NOT_FOUND;
              end
            end
            dtq_pkg::OP_TICK: begin
              out_fired_next = 1'b1;
              out_id_next    = done.best_id;
              res_time       = done.best_end;
              out_last_next  = (done.count == CNT_W'(1));
              clr.en         = 1'b1;
              clr.slot       = done.slot;
              if (done.count != CNT_W'(1)) begin
                inj_next         = '0;
                inj_next.valid   = 1'b1;
                inj_next.op      = dtq_pkg::OP_TICK;
                inj_next.key_end = cur_time;
                state_next       = dtq_pkg::ST_SWEEP;
              end
            end
            default: begin
            end
          endcase
        end
      end

      default: begin
        state_next = dtq_pkg::ST_IDLE;
      end
    endcase

    out_time_next = '0;
    out_time_next[MIN_W-1:0] = res_time[MIN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dtq_pkg::ST_IDLE;
      cur_time  <= '0;
      next_id   <= '0;
      inj.valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cur_time  <= cur_time_next;
      next_id   <= next_id_next;
      inj       <= inj_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    done <= done_next;
    if (out_load) begin
      out_fired  <= out_fired_next;
      out_id     <= out_id_next;
      out_status <= out_status_next;
      out_time   <= out_time_next;
      out_last   <= out_last_next;
    end
  end

  // At most one request packet travels the cell row at any time.
  a_single_packet: assert property (@(posedge clk) disable iff (rst)
    $onehot0(chain_vld))
    else $error("more than one packet in the cell row");

  // A packet leaves the row only while the sequencer waits for it.
  a_return_in_sweep: assert property (@(posedge clk) disable iff (rst)
    chain[CAPACITY].valid |-> (state == dtq_pkg::ST_SWEEP))
    else $error("packet returned outside of a sweep");

  // A successful registration advances the id counter by exactly one.
  a_id_advance: assert property (@(posedge clk) disable iff (rst)
    (out_load && done.found &&
     ((done.op == dtq_pkg::OP_REG_REL) || (done.op == dtq_pkg::OP_REG_ABS)))
    |=> (next_id == $past(next_id) + ID_W'(1)))
    else $error("id counter did not advance on registration");

endmodule

`default_nettype wire

// File: tb/sv/deadline_timer_queue_tb.sv
// Self-checking testbench of deadline_timer_queue: a directed table, then random commands.
// Depends on dtq_pkg, dtq_req_if, dtq_rsp_if and the deadline_timer_queue top level.
module deadline_timer_queue_tb;
  import dtq_pkg::*;

  localparam int SLOTS = CAPACITY_DEFAULT;
  localparam logic [TIME_FIELD_W-1:0] T_MAX = '1;
  localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;
  localparam int RANDOM_ITEMS = 430;
  localparam int LONG_HOLD = 400;
  localparam int HOLD_AFTER = 150;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 4 * (SLOTS + 3);

  typedef struct packed {
    logic                    fired;
    logic [ID_W-1:0]         rid;
    status_t                 status;
    logic [TIME_FIELD_W-1:0] rtime;
    logic                    last;
  } timer_result_t;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic [TIME_FIELD_W-1:0] tv;
    logic [ID_W-1:0]         tid;
    logic [4:0]              reps;
    logic                    typed;
    timer_result_t           want;
  } stim_row_t;

  localparam timer_result_t NO_TYPED = '0;

  // After reset time is zero and ids count up from zero; the fill rows fill the table before
  // the full-table attempt; the last of the final three ticks expires fifteen timers.
  stim_row_t directed_rows [0:21] = '{
    '{OP_QUERY_END, 48'd0, 32'd0, 5'd1, 1'b1, '{1'b0, 32'd0, STATUS_NOT_FOUND, 48'd0, 1'b1}},
    '{OP_CANCEL, 48'd0, 32'hFFFF_FFFF, 5'd1, 1'b1,
      '{1'b0, 32'hFFFF_FFFF, STATUS_NOT_FOUND, 48'd0, 1'b1}},
    '{OP_QUERY_REM, 48'd0, 32'd0, 5'd1, 1'b1, '{1'b0, 32'd0, STATUS_NOT_FOUND, 48'd0, 1'b1}},
    '{OP_TICK, 48'd0, 32'd0, 5'd1, 1'b0, NO_TYPED},
    '{OP_REG_REL, 48'd0, 32'd0, 5'd1, 1'b1, '{1'b0, 32'd0, STATUS_OK, 48'd1, 1'b1}},
    '{OP_REG_REL, T_MAX, 32'd0, 5'd1, 1'b1, '{1'b0, 32'd1, STATUS_OK, T_MAX, 1'b1}},
    '{OP_REG_ABS, 48'd0, 32'd0, 5'd1, 1'b1, '{1'b0, 32'd2, STATUS_OK, 48'd0, 1'b1}},
    '{OP_REG_ABS, 48'd5, 32'd0, 5'd1, 1'b1, '{1'b0, 32'd3, STATUS_OK, 48'd5, 1'b1}},
    '{OP_QUERY_REM, 48'd0, 32'd1, 5'd1, 1'b1, '{1'b0, 32'd1, STATUS_OK, T_MAX - 48'd1, 1'b1}},
    '{OP_QUERY_REM, 48'd0, 32'd2, 5'd1, 1'b1, '{1'b0, 32'd2, STATUS_OK, 48'd0, 1'b1}},
    '{OP_QUERY_END, 48'd0, 32'd3, 5'd1, 1'b1, '{1'b0, 32'd3, STATUS_OK, 48'd5, 1'b1}},
    '{OP_TICK, 48'd0, 32'd0, 5'd1, 1'b0, NO_TYPED},
    '{OP_CANCEL, 48'd0, 32'd3, 5'd1, 1'b1, '{1'b0, 32'd3, STATUS_OK, 48'd0, 1'b1}},
    '{OP_CANCEL, 48'd0, 32'd3, 5'd1, 1'b1, '{1'b0, 32'd3, STATUS_NOT_FOUND, 48'd0, 1'b1}},
    '{OP_REG_ABS, 48'd4, 32'd0, 5'd1, 1'b1, '{1'b0, 32'd4, STATUS_OK, 48'd4, 1'b1}},
    '{OP_REG_REL, 48'd2, 32'd0, 5'd1, 1'b1, '{1'b0, 32'd5, STATUS_OK, 48'd4, 1'b1}},
    '{OP_RSVD6, T_MAX, 32'hFFFF_FFFF, 5'd1, 1'b0, NO_TYPED},
    '{OP_RSVD7, 48'd0, 32'd0, 5'd1, 1'b0, NO_TYPED},
    '{OP_TICK, 48'd0, 32'd0, 5'd2, 1'b0, NO_TYPED},
    '{OP_REG_REL, 48'd3, 32'd0, 5'd15, 1'b0, NO_TYPED},
    '{OP_REG_ABS, T_MAX, 32'd0, 5'd1, 1'b1, '{1'b0, 32'd0, STATUS_FULL, T_MAX, 1'b1}},
    '{OP_TICK, 48'd0, 32'd0, 5'd3, 1'b0, NO_TYPED}
  };

  logic clk = 1'b0;
  logic rst;

  dtq_req_if req_ch ();
  dtq_rsp_if rsp_ch ();

  deadline_timer_queue u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #4 clk = ~clk;

  logic [TIME_FIELD_W-1:0] sw_now;
  logic                    slot_live [SLOTS];
  logic [ID_W-1:0]         slot_id [SLOTS];
  logic [TIME_FIELD_W-1:0] slot_end [SLOTS];
  logic [ID_W-1:0]         id_next;

  timer_result_t step_results [$];
  timer_result_t awaited_results [$];
  int mismatch_count = 0;
  int sent_count = 0;
  int burst_left = 0;

  task automatic compute_timer_results(input logic [OP_W-1:0] op,
                                       input logic [TIME_FIELD_W-1:0] tv,
                                       input logic [ID_W-1:0] tid);
    int best;
    int hit;
    int free;
    logic do_reg;
    logic [TIME_FIELD_W-1:0] end_t;
    timer_result_t r;
    step_results.delete();
    do_reg = 1'b0;
    end_t = '0;
    hit = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit < 0 && slot_live[i] && slot_id[i] == tid) hit = i;
    end
    case (op)
      OP_TICK: begin
        if (sw_now != T_MAX) sw_now = sw_now + 1'b1;
        do begin
          best = -1;
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_live[i] && slot_end[i] <= sw_now) begin
              if (best < 0 || slot_end[i] < slot_end[best] ||
                  (slot_end[i] == slot_end[best] && slot_id[i] < slot_id[best])) best = i;
            end
          end
          if (best >= 0) begin
            slot_live[best] = 1'b0;
            r = '{1'b1, slot_id[best], STATUS_OK, slot_end[best], 1'b0};
            step_results.push_back(r);
          end
        end while (best >= 0);
        if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
      end
      OP_REG_REL: begin
        do_reg = 1'b1;
        end_t = (tv > T_MAX - sw_now) ? T_MAX : sw_now + tv;
      end
      OP_REG_ABS: begin
        do_reg = 1'b1;
        end_t = tv;
      end
      OP_CANCEL: begin
        if (hit >= 0) slot_live[hit] = 1'b0;
        r = '{1'b0, tid, (hit >= 0) ? STATUS_OK : STATUS_NOT_FOUND, 48'd0, 1'b1};
        step_results.push_back(r);
      end
      OP_QUERY_REM: begin
        if (hit < 0) r = '{1'b0, tid, STATUS_NOT_FOUND, 48'd0, 1'b1};
        else r = '{1'b0, tid, STATUS_OK,
                   (slot_end[hit] > sw_now) ? slot_end[hit] - sw_now : 48'd0, 1'b1};
        step_results.push_back(r);
      end
      OP_QUERY_END: begin
        if (hit < 0) r = '{1'b0, tid, STATUS_NOT_FOUND, 48'd0, 1'b1};
        else r = '{1'b0, tid, STATUS_OK, slot_end[hit], 1'b1};
        step_results.push_back(r);
      end
      default: begin
      end
    endcase
    if (do_reg) begin
      free = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (free < 0 && !slot_live[i]) free = i;
      end
      if (free >= 0) begin
        slot_live[free] = 1'b1;
        slot_id[free] = id_next;
        slot_end[free] = end_t;
        r = '{1'b0, id_next, STATUS_OK, end_t, 1'b1};
        id_next = id_next + 1'b1;
      end else begin
        r = '{1'b0, 32'd0, STATUS_FULL, end_t, 1'b1};
      end
      step_results.push_back(r);
    end
  endtask

  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [TIME_FIELD_W-1:0] tv,
                          input logic [ID_W-1:0] tid, input logic typed,
                          input timer_result_t typed_res);
    req_ch.valid <= 1'b1;
    req_ch.op <= op;
    req_ch.time_value <= tv;
    req_ch.timer_id <= tid;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    compute_timer_results(op, tv, tid);
    if (typed) begin
      awaited_results.push_back(typed_res);
    end else begin
      foreach (step_results[i]) awaited_results.push_back(step_results[i]);
    end
    if (op != OP_RSVD6 && op != OP_RSVD7) sent_count++;
  endtask

  task automatic pause_between();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 11);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    timer_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (awaited_results.size() == 0) begin
        $error("result transfer with nothing awaited: id %0h", rsp_ch.result_id);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("fired", want.fired, rsp_ch.fired);
        check_field("result_id", want.rid, rsp_ch.result_id);
        check_field("status", want.status, rsp_ch.status);
        check_field("result_time", want.rtime, rsp_ch.result_time);
        check_field("last", want.last, rsp_ch.last);
      end
    end
  end

  initial begin : receiver
    int ready_run;
    int stall_run;
    logic hold_done;
    hold_done = 1'b0;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!hold_done && sent_count >= HOLD_AFTER) begin
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        ready_run = $urandom_range(1, 24);
        stall_run = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        rsp_ch.ready <= 1'b1;
        repeat (ready_run) @(posedge clk);
        if (stall_run > 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (stall_run) @(posedge clk);
        end
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : sender
    logic [OP_W-1:0] op;
    logic [TIME_FIELD_W-1:0] tv;
    logic [ID_W-1:0] tid;
    logic [63:0] wide;
    int target;
    int pick;
    int live_n;
    int k;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.op <= OP_TICK;
    req_ch.time_value <= '0;
    req_ch.timer_id <= '0;
    sw_now = '0;
    id_next = '0;
    for (int i = 0; i < SLOTS; i++) slot_live[i] = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      repeat (directed_rows[r].reps) begin
        send_cmd(directed_rows[r].op, directed_rows[r].tv, directed_rows[r].tid,
                 directed_rows[r].typed, directed_rows[r].want);
        pause_between();
      end
    end

    // Random part: mostly short deadlines so timers keep expiring, with some far
    // deadlines that pile up and fill the table, and cancels or queries, mostly on live ids.
    target = sent_count + RANDOM_ITEMS;
    while (sent_count < target) begin
      wide = {$urandom(), $urandom()};
      tid = $urandom();
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        op = OP_TICK;
        tv = wide[47:0];
      end else if (pick < 55) begin
        op = OP_REG_REL;
        k = $urandom_range(0, 15);
        if (k == 0) tv = T_MAX;
        else if (k < 3) tv = wide[47:0];
        else tv = $urandom_range(0, 24);
      end else if (pick < 67) begin
        op = OP_REG_ABS;
        k = $urandom_range(0, 15);
        if (k < 2) tv = wide[47:0];
        else if (k == 2) tv = '0;
        else if (k < 5) tv = (sw_now > 48'd8) ? sw_now - $urandom_range(0, 8) : '0;
        else tv = sw_now + $urandom_range(0, 24);
      end else if (pick < 97) begin
        if (pick < 79) op = OP_CANCEL;
        else if (pick < 88) op = OP_QUERY_REM;
        else op = OP_QUERY_END;
        tv = wide[47:0];
        live_n = 0;
        for (int i = 0; i < SLOTS; i++) if (slot_live[i]) live_n++;
        if (live_n > 0 && $urandom_range(0, 3) != 0) begin
          k = $urandom_range(0, live_n - 1);
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_live[i]) begin
              if (k == 0) tid = slot_id[i];
              k--;
            end
          end
        end else if ($urandom_range(0, 1) == 0) begin
          tid = id_next - $urandom_range(0, 8);
        end
      end else begin
        op = ($urandom_range(0, 1) == 0) ? OP_RSVD6 : OP_RSVD7;
        tv = wide[47:0];
      end
      send_cmd(op, tv, tid, 1'b0, NO_TYPED);
      pause_between();
    end

    req_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
